@@ rtl/ir_distance_linearizer_defines.svh @@
// Assertion helpers for the IR distance linearizer.
// Both expect signals named clk and rst in the scope where they are used.
`ifndef IR_DISTANCE_LINEARIZER_DEFINES_SVH
`define IR_DISTANCE_LINEARIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IRDL_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define IRDL_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ rtl/irdl_pkg.sv @@
package irdl_pkg;

  localparam int SAMPLE_BITS_DEF = 12;

  localparam int CODE_W     = 12;
  localparam int DIST_W     = 16;
  localparam int FAULT_W    = 2;
  localparam int VOLT_W     = 16;
  localparam int ACC_W      = 24;
  localparam int MUL_B_W    = VOLT_W + 1;
  localparam int PROD_W     = ACC_W + MUL_B_W;
  localparam int FRAC_SHIFT = 14;
  localparam int OUT_SHIFT  = 4;
  localparam int COEF_N     = 4;
  localparam int COEF_IDX_W = $clog2(COEF_N);
  localparam int STEP_W     = 4;

  // 3.3 V full scale and segment boundaries, all unsigned Q2.14.
  localparam logic [VOLT_W-1:0] VREF_Q14 = 16'd54067;
  localparam logic [VOLT_W-1:0] TH_FLAT  = 16'd36536;
  localparam logic [VOLT_W-1:0] TH_CUBIC = 16'd8519;
  localparam logic [VOLT_W-1:0] TH_QUAD  = 16'd3932;

  localparam logic [CODE_W-1:0] LOW_LIMIT_RST  = 12'd15;
  localparam logic [CODE_W-1:0] HIGH_LIMIT_RST = 12'd4000;

  typedef enum logic [0:0] {
    REG_LOW_LIMIT  = 1'b0,
    REG_HIGH_LIMIT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEG_QUAD_LO = 2'd0,
    SEG_QUAD_HI = 2'd1,
    SEG_CUBIC   = 2'd2,
    SEG_FLAT    = 2'd3
  } seg_t;

  // Every segment runs as a cubic; shorter polynomials get leading zeros,
  // and the flat segment is the constant 1.0 in Q.12.
  localparam logic signed [ACC_W-1:0] COEF [4][COEF_N] = '{
    '{24'sd0,       24'sd3824271, -24'sd1792451, 24'sd292082},
    '{24'sd0,       24'sd259056,  -24'sd336642,  24'sd146391},
    '{-24'sd14785,  24'sd76427,   -24'sd136536,  24'sd92324},
    '{24'sd0,       24'sd0,        24'sd0,       24'sd4096}
  };

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_EMIT = 4'd10;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_VOLT_F,
    MUL_VOLT_B,
    MUL_ACC_F,
    MUL_ACC_B
  } mul_sel_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_VOLT_F,
    WB_VOLT_B,
    WB_HORNER_F,
    WB_HORNER_B
  } wb_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_ACCEPT,
    JMP_EMIT
  } jmp_t;

  typedef struct packed {
    mul_sel_t                mul;
    wb_sel_t                 wb;
    logic [COEF_IDX_W-1:0]   coef_idx;
    jmp_t                    jmp;
    step_t                   target;
  } ucode_t;

  function automatic seg_t seg_of(input logic [VOLT_W-1:0] v);
    seg_t s;
    if (v > TH_FLAT) begin
      s = SEG_FLAT;
    end else if (v > TH_CUBIC) begin
      s = SEG_CUBIC;
    end else if (v > TH_QUAD) begin
      s = SEG_QUAD_HI;
    end else begin
      s = SEG_QUAD_LO;
    end
    return s;
  endfunction

  // Control store. The multiplier result of one step is consumed by the
  // write-back of the next, so the two channels alternate on the multiplier.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{mul: MUL_NONE, wb: WB_NONE, coef_idx: '0, jmp: JMP_NEXT, target: STEP_IDLE};
    unique case (s)
      4'd0: begin
        w.jmp    = JMP_ACCEPT;
        w.target = STEP_EMIT;
      end
      4'd1: begin
        w.mul = MUL_VOLT_F;
      end
      4'd2: begin
        w.mul = MUL_VOLT_B;
        w.wb  = WB_VOLT_F;
      end
      4'd3: begin
        w.mul = MUL_ACC_F;
        w.wb  = WB_VOLT_B;
      end
      4'd4: begin
        w.mul      = MUL_ACC_B;
        w.wb       = WB_HORNER_F;
        w.coef_idx = 2'd1;
      end
      4'd5: begin
        w.mul      = MUL_ACC_F;
        w.wb       = WB_HORNER_B;
        w.coef_idx = 2'd1;
      end
      4'd6: begin
        w.mul      = MUL_ACC_B;
        w.wb       = WB_HORNER_F;
        w.coef_idx = 2'd2;
      end
      4'd7: begin
        w.mul      = MUL_ACC_F;
        w.wb       = WB_HORNER_B;
        w.coef_idx = 2'd2;
      end
      4'd8: begin
        w.mul      = MUL_ACC_B;
        w.wb       = WB_HORNER_F;
        w.coef_idx = 2'd3;
      end
      4'd9: begin
        w.wb       = WB_HORNER_B;
        w.coef_idx = 2'd3;
      end
      4'd10: begin
        w.jmp    = JMP_EMIT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/irdl_if.sv @@
interface irdl_in_if;
  import irdl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] front_sample;
  logic [CODE_W-1:0] back_sample;
  logic              conversion_ok;
  modport source(output valid, front_sample, back_sample, conversion_ok, input ready);
  modport sink(input valid, front_sample, back_sample, conversion_ok, output ready);
endinterface

interface irdl_out_if;
  import irdl_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CODE_W-1:0]        front_code;
  logic signed [DIST_W-1:0] front_distance;
  logic [CODE_W-1:0]        back_code;
  logic signed [DIST_W-1:0] back_distance;
  logic [FAULT_W-1:0]       fault_bits;
  logic                     status;
  modport source(output valid, front_code, front_distance, back_code, back_distance,
                 fault_bits, status, input ready);
  modport sink(input valid, front_code, front_distance, back_code, back_distance,
               fault_bits, status, output ready);
endinterface

interface irdl_cfg_if;
  import irdl_pkg::*;
  logic              valid;
  logic              ready;
  cfg_reg_t          index;
  logic [CODE_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/irdl_datapath.sv @@
module irdl_datapath #(
  parameter int SAMPLE_BITS = irdl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  irdl_pkg::ucode_t                   uc,
  input  logic [irdl_pkg::CODE_W-1:0]        code_f,
  input  logic [irdl_pkg::CODE_W-1:0]        code_b,
  output logic signed [irdl_pkg::DIST_W-1:0] dist_f,
  output logic signed [irdl_pkg::DIST_W-1:0] dist_b
);
  import irdl_pkg::*;

  localparam logic signed [PROD_W-1:0] VOLT_HALF    = PROD_W'(1) << (SAMPLE_BITS - 1);
  localparam logic signed [PROD_W-1:0] RND_UP       = PROD_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [PROD_W-1:0] RND_DN       = RND_UP - PROD_W'(1);
  localparam logic signed [ACC_W-1:0]  OUT_RND_UP   = ACC_W'(1) << (OUT_SHIFT - 1);
  localparam logic signed [ACC_W-1:0]  OUT_RND_DN   = OUT_RND_UP - ACC_W'(1);
  localparam int                       D8_W         = ACC_W - OUT_SHIFT;
  localparam logic signed [D8_W-1:0]   DIST_MAX     = D8_W'(32767);
  localparam logic signed [D8_W-1:0]   DIST_MIN     = -D8_W'(32768);

  logic signed [ACC_W-1:0]   mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  volt_sum;
  logic [VOLT_W-1:0]         vq;
  seg_t                      vq_seg;
  logic signed [PROD_W-1:0]  rnd_sum;
  logic signed [ACC_W-1:0]   rnd;

  logic [VOLT_W-1:0]       v_f;
  logic [VOLT_W-1:0]       v_b;
  seg_t                    seg_f;
  seg_t                    seg_b;
  logic signed [ACC_W-1:0] acc_f;
  logic signed [ACC_W-1:0] acc_b;

  // Q.12 to Q.8 with round half away from zero, then clamp to 16 bits.
  function automatic logic signed [DIST_W-1:0] to_dist(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    logic signed [D8_W-1:0]  d;
    logic signed [D8_W-1:0]  c;
    s = a + (a[ACC_W-1] ? OUT_RND_DN : OUT_RND_UP);
    d = s[ACC_W-1:OUT_SHIFT];
    if (d > DIST_MAX) begin
      c = DIST_MAX;
    end else if (d < DIST_MIN) begin
      c = DIST_MIN;
    end else begin
      c = d;
    end
    return c[DIST_W-1:0];
  endfunction

  always_comb begin
    unique case (uc.mul)
      MUL_VOLT_F: begin
        mul_a = ACC_W'(code_f);
        mul_b = MUL_B_W'(VREF_Q14);
      end
      MUL_VOLT_B: begin
        mul_a = ACC_W'(code_b);
        mul_b = MUL_B_W'(VREF_Q14);
      end
      MUL_ACC_F: begin
        mul_a = acc_f;
        mul_b = {1'b0, v_f};
      end
      MUL_ACC_B: begin
        mul_a = acc_b;
        mul_b = {1'b0, v_b};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Voltage: round(code * Vref / 2^SAMPLE_BITS), always below 2^16.
  assign volt_sum = prod + VOLT_HALF;
  assign vq       = volt_sum[SAMPLE_BITS +: VOLT_W];
  assign vq_seg   = seg_of(vq);

  // Negative values add one less so the shift rounds half away from zero.
  assign rnd_sum = prod + (prod[PROD_W-1] ? RND_DN : RND_UP);
  assign rnd     = rnd_sum[FRAC_SHIFT +: ACC_W];

  always_ff @(posedge clk) begin
    unique case (uc.wb)
      WB_VOLT_F: begin
        v_f   <= vq;
        seg_f <= vq_seg;
        acc_f <= COEF[vq_seg][uc.coef_idx];
      end
      WB_VOLT_B: begin
        v_b   <= vq;
        seg_b <= vq_seg;
        acc_b <= COEF[vq_seg][uc.coef_idx];
      end
      WB_HORNER_F: begin
        acc_f <= rnd + COEF[seg_f][uc.coef_idx];
      end
      WB_HORNER_B: begin
        acc_b <= rnd + COEF[seg_b][uc.coef_idx];
      end
      default: begin
      end
    endcase
  end

  assign dist_f = to_dist(acc_f);
  assign dist_b = to_dist(acc_b);

endmodule

@@ rtl/ir_distance_linearizer.sv @@
// Two-channel IR distance linearizer.
// The sample channel carries one front and one back converter code plus a
// flag that both conversions succeeded; each transaction yields exactly one
// transaction on the result channel with both codes, both distances in cm
// (signed Q7.8), the fault bits and a status bit.
// The cfg channel writes the low and high fault limits; it is always ready
// and should be used only while no sample is in flight.
// A sample is taken in the idle step of a microcoded sequencer and its
// result is registered at the emit step, after the program has run on the
// single shared multiplier: one voltage and three Horner products per
// channel, each followed by a rounding write-back. Only then is the next
// sample taken. A failed conversion skips the arithmetic and goes straight
// to the emit step. The result register holds while the receiver stalls;
// the next sample is still taken and worked on, and the sequencer waits
// only at its final step until the register is free.
// Reset returns the sequencer to idle, clears the result valid and the fault
// bits, and sets the limits to 15 and 4000.
`include "ir_distance_linearizer_defines.svh"

module ir_distance_linearizer #(
  parameter int SAMPLE_BITS = irdl_pkg::SAMPLE_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  irdl_in_if.sink     sample,
  irdl_out_if.source  result,
  irdl_cfg_if.sink    cfg
);
  import irdl_pkg::*;

  localparam logic [CODE_W-1:0] CODE_MASK =
    (SAMPLE_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((1 << SAMPLE_BITS) - 1);

  step_t  step;
  step_t  step_next;
  ucode_t uc;
  logic   accept;
  logic   out_free;

  logic [CODE_W-1:0]  low_limit;
  logic [CODE_W-1:0]  high_limit;
  logic [FAULT_W-1:0] fault_reg;
  logic [CODE_W-1:0]  in_code_f;
  logic [CODE_W-1:0]  in_code_b;
  logic [CODE_W-1:0]  code_f;
  logic [CODE_W-1:0]  code_b;
  logic               conv_ok;

  logic signed [DIST_W-1:0] dist_f;
  logic signed [DIST_W-1:0] dist_b;

  assign uc           = ucode_rom(step);
  assign sample.ready = (uc.jmp == JMP_ACCEPT);
  assign accept       = sample.valid && sample.ready;
  assign out_free     = !result.valid || result.ready;
  assign cfg.ready    = 1'b1;

  assign in_code_f = sample.front_sample & CODE_MASK;
  assign in_code_b = sample.back_sample & CODE_MASK;

  always_comb begin
    unique case (uc.jmp)
      JMP_NEXT: step_next = step + step_t'(1);
      JMP_GOTO: step_next = uc.target;
      JMP_ACCEPT: begin
        if (!accept) begin
          step_next = step;
        end else if (sample.conversion_ok) begin
          step_next = step + step_t'(1);
        end else begin
          step_next = uc.target;
        end
      end
      JMP_EMIT: step_next = out_free ? uc.target : step;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_limit  <= LOW_LIMIT_RST;
      high_limit <= HIGH_LIMIT_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LOW_LIMIT:  low_limit  <= cfg.data;
        REG_HIGH_LIMIT: high_limit <= cfg.data;
      endcase
    end
  end

  // A failed conversion leaves the fault bits as they were.
  always_ff @(posedge clk) begin
    if (rst) begin
      fault_reg <= '0;
    end else if (accept && sample.conversion_ok) begin
      fault_reg[0] <= (in_code_f < low_limit) || (in_code_f >= high_limit);
      fault_reg[1] <= (in_code_b < low_limit) || (in_code_b >= high_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      code_f  <= in_code_f;
      code_b  <= in_code_b;
      conv_ok <= sample.conversion_ok;
    end
  end

  irdl_datapath #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk    (clk),
    .uc     (uc),
    .code_f (code_f),
    .code_b (code_b),
    .dist_f (dist_f),
    .dist_b (dist_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (uc.jmp == JMP_EMIT && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.jmp == JMP_EMIT && out_free) begin
      result.front_code     <= conv_ok ? code_f : '0;
      result.back_code      <= conv_ok ? code_b : '0;
      result.front_distance <= conv_ok ? dist_f : '0;
      result.back_distance  <= conv_ok ? dist_b : '0;
      result.fault_bits     <= fault_reg;
      result.status         <= !conv_ok;
    end
  end

  `IRDL_ASSERT_NXT(a_ok_starts_program, accept && sample.conversion_ok,
                   step == STEP_IDLE + step_t'(1), "good sample did not start the program")
  `IRDL_ASSERT_NXT(a_fail_skips, accept && !sample.conversion_ok,
                   step == STEP_EMIT, "failed conversion did not go to the emit step")
  `IRDL_ASSERT_NXT(a_emit_holds, step == STEP_EMIT && result.valid && !result.ready,
                   step == STEP_EMIT, "sequencer left the emit step while the result stalled")
  `IRDL_ASSERT_IMP(a_fail_zero, result.valid && result.status,
                   result.front_distance == '0 && result.back_distance == '0,
                   "failed conversion reported a nonzero distance")

endmodule
